// ===== sv/rsi_pkg.sv =====
package rsi_pkg;

	// number format
	localparam int FRAC_BITS = 16;
	localparam int CRD_W     = 32;
	localparam int DIR_W     = 18;
	localparam int RAD_W     = 31;
	localparam int DIST_W    = 31;

	// internal widths, all exact
	localparam int OC_W   = CRD_W + 1;
	localparam int DP_W   = OC_W + DIR_W;
	localparam int DOT_W  = DP_W + 2;
	localparam int B_W    = DOT_W - FRAC_BITS;
	localparam int BL_W   = (B_W + 1) / 2;
	localparam int BH_W   = B_W - BL_W;
	localparam int BB_W   = 2 * B_W;
	localparam int OC2_W  = 2 * OC_W;
	localparam int CMP_W  = (BB_W > OC2_W) ? BB_W + 1 : OC2_W + 1;
	localparam int RR_W   = 2 * RAD_W;
	localparam int H_W    = RR_W;
	localparam int STEPS  = RR_W / 2;
	localparam int T_W    = B_W + 1;
	localparam int P_W    = DIR_W + T_W;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_RADIUS   = 2'd3
	} cfg_reg_t;

	// ray context carried along the pipe
	typedef struct packed {
		logic                    miss;
		logic signed [B_W-1:0]   b;
		logic signed [CRD_W-1:0] ox;
		logic signed [CRD_W-1:0] oy;
		logic signed [CRD_W-1:0] oz;
		logic signed [DIR_W-1:0] dx;
		logic signed [DIR_W-1:0] dy;
		logic signed [DIR_W-1:0] dz;
	} ray_t;

endpackage

// ===== sv/rsi_front.sv =====
module rsi_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [31:0]                      cfg_wdata,
	input  logic signed [rsi_pkg::CRD_W-1:0] origin_x,
	input  logic signed [rsi_pkg::CRD_W-1:0] origin_y,
	input  logic signed [rsi_pkg::CRD_W-1:0] origin_z,
	input  logic signed [rsi_pkg::DIR_W-1:0] dir_x,
	input  logic signed [rsi_pkg::DIR_W-1:0] dir_y,
	input  logic signed [rsi_pkg::DIR_W-1:0] dir_z,
	output logic                             out_valid,
	output rsi_pkg::ray_t                    out_ray,
	output logic [rsi_pkg::H_W-1:0]          out_h2
);

	localparam int OC_W  = rsi_pkg::OC_W;
	localparam int DP_W  = rsi_pkg::DP_W;
	localparam int DOT_W = rsi_pkg::DOT_W;
	localparam int B_W   = rsi_pkg::B_W;
	localparam int BL_W  = rsi_pkg::BL_W;
	localparam int BH_W  = rsi_pkg::BH_W;
	localparam int BB_W  = rsi_pkg::BB_W;
	localparam int OC2_W = rsi_pkg::OC2_W;
	localparam int CMP_W = rsi_pkg::CMP_W;
	localparam int RR_W  = rsi_pkg::RR_W;

	logic signed [rsi_pkg::CRD_W-1:0] center_x_q, center_y_q, center_z_q;
	logic [rsi_pkg::RAD_W-1:0]        radius_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= '0;
		end else if (cfg_we) begin
			case (rsi_pkg::cfg_reg_t'(cfg_index))
				rsi_pkg::REG_CENTER_X: center_x_q <= cfg_wdata;
				rsi_pkg::REG_CENTER_Y: center_y_q <= cfg_wdata;
				rsi_pkg::REG_CENTER_Z: center_z_q <= cfg_wdata;
				rsi_pkg::REG_RADIUS:   radius_q   <= cfg_wdata[rsi_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	logic [7:1] valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid <= '0;
		else         valid <= {valid[6:1], in_valid};
	end

	// s1: center offset, squared radius
	logic signed [OC_W-1:0] ocx_s1, ocy_s1, ocz_s1;
	logic [RR_W-1:0]        rr_s1;
	rsi_pkg::ray_t          ray_s1;

	always_ff @(posedge clk) begin
		ocx_s1 <= OC_W'(center_x_q) - OC_W'(origin_x);
		ocy_s1 <= OC_W'(center_y_q) - OC_W'(origin_y);
		ocz_s1 <= OC_W'(center_z_q) - OC_W'(origin_z);
		rr_s1  <= RR_W'(radius_q) * RR_W'(radius_q);
		ray_s1 <= '{miss: 1'b0, b: '0, ox: origin_x, oy: origin_y, oz: origin_z,
			dx: dir_x, dy: dir_y, dz: dir_z};
	end

	// s2: projection terms and squares
	logic signed [DP_W-1:0]  dpx_s2, dpy_s2, dpz_s2;
	logic signed [OC2_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [RR_W-1:0]         rr_s2;
	rsi_pkg::ray_t           ray_s2;

	always_ff @(posedge clk) begin
		dpx_s2 <= ocx_s1 * ray_s1.dx;
		dpy_s2 <= ocy_s1 * ray_s1.dy;
		dpz_s2 <= ocz_s1 * ray_s1.dz;
		sqx_s2 <= ocx_s1 * ocx_s1;
		sqy_s2 <= ocy_s1 * ocy_s1;
		sqz_s2 <= ocz_s1 * ocz_s1;
		rr_s2  <= rr_s1;
		ray_s2 <= ray_s1;
	end

	// s3: b = floor(dot / 2^F), |oc|^2
	logic signed [DOT_W-1:0] dot;
	logic [OC2_W-1:0]        oc2_s3;
	logic [RR_W-1:0]         rr_s3;
	rsi_pkg::ray_t           ray_pb;
	rsi_pkg::ray_t           ray_s3;

	assign dot = DOT_W'(dpx_s2) + DOT_W'(dpy_s2) + DOT_W'(dpz_s2);

	always_comb begin
		ray_pb   = ray_s2;
		ray_pb.b = B_W'(dot >>> rsi_pkg::FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		oc2_s3 <= $unsigned(sqx_s2) + $unsigned(sqy_s2) + $unsigned(sqz_s2);
		rr_s3  <= rr_s2;
		ray_s3 <= ray_pb;
	end

	// s4: |b| split in halves, partial products
	logic [B_W-1:0]       bmag;
	logic [2*BH_W-1:0]    hh_s4;
	logic [BH_W+BL_W-1:0] hl_s4;
	logic [2*BL_W-1:0]    ll_s4;
	logic [OC2_W-1:0]     oc2_s4;
	logic [RR_W-1:0]      rr_s4;
	rsi_pkg::ray_t        ray_s4;

	assign bmag = ray_s3.b[B_W-1] ? B_W'(-ray_s3.b) : B_W'(ray_s3.b);

	always_ff @(posedge clk) begin
		hh_s4  <= (2*BH_W)'(bmag[B_W-1:BL_W]) * (2*BH_W)'(bmag[B_W-1:BL_W]);
		hl_s4  <= (BH_W+BL_W)'(bmag[B_W-1:BL_W]) * (BH_W+BL_W)'(bmag[BL_W-1:0]);
		ll_s4  <= (2*BL_W)'(bmag[BL_W-1:0]) * (2*BL_W)'(bmag[BL_W-1:0]);
		oc2_s4 <= oc2_s3;
		rr_s4  <= rr_s3;
		ray_s4 <= ray_s3;
	end

	// s5: b^2
	logic [BB_W-1:0]  bb_s5;
	logic [OC2_W-1:0] oc2_s5;
	logic [RR_W-1:0]  rr_s5;
	rsi_pkg::ray_t    ray_s5;

	always_ff @(posedge clk) begin
		bb_s5  <= (BB_W'(hh_s4) << (2*BL_W)) + (BB_W'(hl_s4) << (BL_W+1)) + BB_W'(ll_s4);
		oc2_s5 <= oc2_s4;
		rr_s5  <= rr_s4;
		ray_s5 <= ray_s4;
	end

	// s6: squared perpendicular distance
	logic             gt_s6;
	logic [CMP_W-1:0] d2_s6;
	logic [RR_W-1:0]  rr_s6;
	rsi_pkg::ray_t    ray_s6;

	always_ff @(posedge clk) begin
		gt_s6  <= CMP_W'(oc2_s5) > CMP_W'(bb_s5);
		d2_s6  <= CMP_W'(oc2_s5) - CMP_W'(bb_s5);
		rr_s6  <= rr_s5;
		ray_s6 <= ray_s5;
	end

	// s7: miss test and radicand
	logic [RR_W-1:0] h2_s7;
	rsi_pkg::ray_t   ray_pm;
	rsi_pkg::ray_t   ray_s7;

	always_comb begin
		ray_pm = ray_s6;
		if (gt_s6) begin
			ray_pm.miss = d2_s6 > CMP_W'(rr_s6);
		end
	end

	always_ff @(posedge clk) begin
		ray_s7 <= ray_pm;
		if (gt_s6) begin
			h2_s7 <= rr_s6 - d2_s6[RR_W-1:0];
		end else begin
			h2_s7 <= rr_s6;
		end
	end

	assign out_valid = valid[7];
	assign out_ray   = ray_s7;
	assign out_h2    = h2_s7;

endmodule

// ===== sv/rsi_cell.sv =====
module rsi_cell #(
	parameter int STEP = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  rsi_pkg::ray_t           in_ray,
	input  logic [rsi_pkg::H_W-1:0] in_rem,
	input  logic [rsi_pkg::H_W-1:0] in_res,
	output logic                    out_valid,
	output rsi_pkg::ray_t           out_ray,
	output logic [rsi_pkg::H_W-1:0] out_rem,
	output logic [rsi_pkg::H_W-1:0] out_res
);

	localparam int H_W = rsi_pkg::H_W;
	localparam logic [H_W:0] BIT = (H_W+1)'(1) << (2*STEP);

	logic [H_W:0] trial;
	logic         take;

	// one square-root digit: try res + 4^STEP against the remainder
	assign trial = {1'b0, in_res} + BIT;
	assign take  = {1'b0, in_rem} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else         out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		out_ray <= in_ray;
		if (take) begin
			out_rem <= in_rem - trial[H_W-1:0];
			out_res <= (in_res >> 1) + BIT[H_W-1:0];
		end else begin
			out_rem <= in_rem;
			out_res <= in_res >> 1;
		end
	end

endmodule

// ===== sv/ray_sphere_intersect_unit.sv =====
// Ray/sphere intersection, fully pipelined: one ray word accepted every cycle.
// Done pulses after 7 setup stages, a row of 31 square-root cells, one digit each,
// then 3 stages for root pick and hit point.
// busy stays low; the result stands for one cycle and cannot be stalled.
// Reset clears the sphere registers and all stage valid bits.
module ray_sphere_intersect_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [31:0]                         cfg_wdata,
	input  logic signed [rsi_pkg::CRD_W-1:0]    origin_x,
	input  logic signed [rsi_pkg::CRD_W-1:0]    origin_y,
	input  logic signed [rsi_pkg::CRD_W-1:0]    origin_z,
	input  logic signed [rsi_pkg::DIR_W-1:0]    dir_x,
	input  logic signed [rsi_pkg::DIR_W-1:0]    dir_y,
	input  logic signed [rsi_pkg::DIR_W-1:0]    dir_z,
	output logic                                done,
	output logic                                hit,
	output logic [rsi_pkg::DIST_W-1:0]          hit_distance,
	output logic signed [rsi_pkg::CRD_W-1:0]    point_x,
	output logic signed [rsi_pkg::CRD_W-1:0]    point_y,
	output logic signed [rsi_pkg::CRD_W-1:0]    point_z
);

	localparam int H_W   = rsi_pkg::H_W;
	localparam int STEPS = rsi_pkg::STEPS;
	localparam int T_W   = rsi_pkg::T_W;
	localparam int P_W   = rsi_pkg::P_W;
	localparam int CRD_W = rsi_pkg::CRD_W;
	localparam int SUM_W = P_W - rsi_pkg::FRAC_BITS + 1;

	localparam logic signed [SUM_W-1:0] CRD_MAX = SUM_W'((64'sd1 <<< (CRD_W-1)) - 1);
	localparam logic signed [SUM_W-1:0] CRD_MIN = -SUM_W'(64'sd1 <<< (CRD_W-1));
	localparam logic signed [T_W-1:0]   DIST_MAX =
		T_W'((64'sd1 <<< rsi_pkg::DIST_W) - 1);

	function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [SUM_W-1:0] v);
		if (v > CRD_MAX)      sat_crd = CRD_MAX[CRD_W-1:0];
		else if (v < CRD_MIN) sat_crd = CRD_MIN[CRD_W-1:0];
		else                  sat_crd = v[CRD_W-1:0];
	endfunction

	assign busy = 1'b0;

	// setup stages
	logic            cell_valid [STEPS+1];
	rsi_pkg::ray_t   cell_ray   [STEPS+1];
	logic [H_W-1:0]  cell_rem   [STEPS+1];
	logic [H_W-1:0]  cell_res   [STEPS+1];

	rsi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.origin_z  (origin_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.out_valid (cell_valid[0]),
		.out_ray   (cell_ray[0]),
		.out_h2    (cell_rem[0])
	);

	assign cell_res[0] = '0;

	// row of square-root cells, most significant digit first
	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		rsi_cell #(.STEP(STEPS - 1 - i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cell_valid[i]),
			.in_ray    (cell_ray[i]),
			.in_rem    (cell_rem[i]),
			.in_res    (cell_res[i]),
			.out_valid (cell_valid[i+1]),
			.out_ray   (cell_ray[i+1]),
			.out_rem   (cell_rem[i+1]),
			.out_res   (cell_res[i+1])
		);
	end

	// root pick: nearer positive root, else the farther one
	logic signed [T_W-1:0] h_ext, t1, t2;
	logic                  valid_st, valid_sm;
	logic                  miss_st, miss_sm;
	logic signed [T_W-1:0] t_st, t_sm;
	rsi_pkg::ray_t         ray_st, ray_sm;
	logic signed [P_W-1:0] px_sm, py_sm, pz_sm;

	assign h_ext = T_W'($signed({1'b0, cell_res[STEPS][rsi_pkg::RAD_W-1:0]}));
	assign t1    = T_W'(cell_ray[STEPS].b) - h_ext;
	assign t2    = T_W'(cell_ray[STEPS].b) + h_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_st <= 1'b0;
			valid_sm <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_st <= cell_valid[STEPS];
			valid_sm <= valid_st;
			done     <= valid_sm;
		end
	end

	always_ff @(posedge clk) begin
		ray_st  <= cell_ray[STEPS];
		miss_st <= cell_ray[STEPS].miss || (t2 <= 0);
		t_st    <= (t1 > 0) ? t1 : t2;
	end

	// direction times distance
	always_ff @(posedge clk) begin
		px_sm   <= P_W'(ray_st.dx) * P_W'(t_st);
		py_sm   <= P_W'(ray_st.dy) * P_W'(t_st);
		pz_sm   <= P_W'(ray_st.dz) * P_W'(t_st);
		t_sm    <= t_st;
		miss_sm <= miss_st;
		ray_sm  <= ray_st;
	end

	// output word: saturate distance and point
	always_ff @(posedge clk) begin
		if (miss_sm) begin
			hit          <= 1'b0;
			hit_distance <= '0;
			point_x      <= '0;
			point_y      <= '0;
			point_z      <= '0;
		end else begin
			hit          <= 1'b1;
			hit_distance <= (t_sm > DIST_MAX) ? DIST_MAX[rsi_pkg::DIST_W-1:0]
				: t_sm[rsi_pkg::DIST_W-1:0];
			point_x <= sat_crd(SUM_W'(ray_sm.ox) + SUM_W'(px_sm >>> rsi_pkg::FRAC_BITS));
			point_y <= sat_crd(SUM_W'(ray_sm.oy) + SUM_W'(py_sm >>> rsi_pkg::FRAC_BITS));
			point_z <= sat_crd(SUM_W'(ray_sm.oz) + SUM_W'(pz_sm >>> rsi_pkg::FRAC_BITS));
		end
	end

endmodule

// ===== sv/rsi_checker.sv =====
module rsi_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic                             hit,
	input logic [rsi_pkg::DIST_W-1:0]       hit_distance,
	input logic signed [rsi_pkg::CRD_W-1:0] point_x,
	input logic signed [rsi_pkg::CRD_W-1:0] point_y,
	input logic signed [rsi_pkg::CRD_W-1:0] point_z
);

	// every accepted ray yields exactly one word
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && arst_n |-> ##41 done)
		else $error("accepted ray produced no result word");

	a_word_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, 41))
		else $error("result word without an accepted ray");

	// a miss word is all zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> hit_distance == 0 && point_x == 0 && point_y == 0 && point_z == 0)
		else $error("miss word carries nonzero payload");

	// a hit lies strictly ahead of the origin
	a_hit_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> hit_distance != 0)
		else $error("hit at zero distance");

endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (.*);

// ===== verif/tb_ray_sphere_intersect_unit.sv =====
module tb_ray_sphere_intersect_unit;

	localparam int LATENCY   = 41;
	localparam int CYCLE_CAP = 400000;
	localparam int N_RANDOM  = 1450;

	// one hit result word
	typedef struct {
		logic        hit;
		logic [30:0] hdist;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} hit_word_t;

	// one ray word
	typedef struct {
		logic [31:0] ox;
		logic [31:0] oy;
		logic [31:0] oz;
		logic [17:0] dx;
		logic [17:0] dy;
		logic [17:0] dz;
	} ray_word_t;

	logic clk, arst_n;
	logic start, busy;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_wdata;
	logic signed [31:0] origin_x, origin_y, origin_z;
	logic signed [17:0] dir_x, dir_y, dir_z;
	logic done, hit;
	logic [30:0] hit_distance;
	logic signed [31:0] point_x, point_y, point_z;

	ray_sphere_intersect_unit dut (.*);

	// sphere copy held by the predictor
	logic signed [31:0] sph_cx, sph_cy, sph_cz;
	logic [30:0] sph_r;

	hit_word_t pending_hits[$];
	int mismatches;
	int cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// bit-by-bit integer square root
	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] sat_crd(input logic signed [127:0] x);
		if (x > 128'sd2147483647)
			return 32'sh7fffffff;
		if (x < -128'sd2147483648)
			return 32'sh80000000;
		return x[31:0];
	endfunction

	// intersection of one ray with the configured sphere
	function automatic hit_word_t predict_hit(input ray_word_t r);
		hit_word_t w;
		logic signed [127:0] o[3], d[3], oc[3];
		logic signed [127:0] dot, b, oc2, bb, rr, d2, h, t1, t2, t, p;
		logic [63:0] h2;
		o[0] = $signed(r.ox); o[1] = $signed(r.oy); o[2] = $signed(r.oz);
		d[0] = $signed(r.dx); d[1] = $signed(r.dy); d[2] = $signed(r.dz);
		oc[0] = $signed(sph_cx) - o[0];
		oc[1] = $signed(sph_cy) - o[1];
		oc[2] = $signed(sph_cz) - o[2];
		w = '{hit: 1'b0, hdist: '0, px: '0, py: '0, pz: '0};
		dot = oc[0] * d[0] + oc[1] * d[1] + oc[2] * d[2];
		b = dot >>> rsi_pkg::FRAC_BITS;
		oc2 = oc[0] * oc[0] + oc[1] * oc[1] + oc[2] * oc[2];
		bb = b * b;
		rr = $signed({97'd0, sph_r}) * $signed({97'd0, sph_r});
		if (oc2 > bb) begin
			d2 = oc2 - bb;
			if (d2 > rr)
				return w;
			h2 = 64'(rr - d2);
		end else begin
			h2 = 64'(rr);
		end
		h = $signed({64'd0, isqrt(h2)});
		t1 = b - h;
		t2 = b + h;
		if (t2 <= 0)
			return w;
		t = (t1 > 0) ? t1 : t2;
		w.hit = 1'b1;
		w.hdist = (t > 128'sd2147483647) ? 31'h7fffffff : t[30:0];
		p = o[0] + ((d[0] * t) >>> rsi_pkg::FRAC_BITS); w.px = sat_crd(p);
		p = o[1] + ((d[1] * t) >>> rsi_pkg::FRAC_BITS); w.py = sat_crd(p);
		p = o[2] + ((d[2] * t) >>> rsi_pkg::FRAC_BITS); w.pz = sat_crd(p);
		return w;
	endfunction

	// compare each done word against the oldest prediction
	always @(posedge clk) begin
		hit_word_t e;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word at %0t", $realtime);
			end else begin
				e = pending_hits.pop_front();
				if (hit !== e.hit || hit_distance !== e.hdist || point_x !== e.px ||
				    point_y !== e.py || point_z !== e.pz) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %b %h %h %h %h got %b %h %h %h %h",
							e.hit, e.hdist, e.px, e.py, e.pz,
							hit, hit_distance, point_x, point_y, point_z);
				end
			end
		end
	end

	// cycle watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input rsi_pkg::cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			rsi_pkg::REG_CENTER_X: sph_cx = val;
			rsi_pkg::REG_CENTER_Y: sph_cy = val;
			rsi_pkg::REG_CENTER_Z: sph_cz = val;
			rsi_pkg::REG_RADIUS:   sph_r = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_sphere(input logic [31:0] cx, cy, cz, rad);
		write_reg(rsi_pkg::REG_CENTER_X, cx);
		write_reg(rsi_pkg::REG_CENTER_Y, cy);
		write_reg(rsi_pkg::REG_CENTER_Z, cz);
		write_reg(rsi_pkg::REG_RADIUS, rad);
	endtask

	// drain: wait for all words, then let the pipe settle; caller is at a falling edge
	task automatic drain_pipe();
		start = 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// issue one ray; caller is at a falling edge
	task automatic send_ray(input ray_word_t r, input bit gaps);
		while (gaps && $urandom_range(99) < 22) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		origin_x = r.ox; origin_y = r.oy; origin_z = r.oz;
		dir_x = r.dx; dir_y = r.dy; dir_z = r.dz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_hits.push_back(predict_hit(r));
		@(negedge clk);
	endtask

	function automatic logic [17:0] rand_dir();
		case ($urandom_range(4))
			0: return 18'(65536);
			1: return -18'sd65536;
			2: return 18'($urandom);
			default: return 18'($signed($urandom_range(131072)) - 65536);
		endcase
	endfunction

	function automatic logic [31:0] rand_crd(input int span);
		if ($urandom_range(9) == 0)
			return $urandom;
		return 32'($signed($urandom_range(2 * span)) - span);
	endfunction

	// directed rays: sphere of radius 1 at origin after reset config
	typedef struct {
		ray_word_t r;
		bit        known;
		hit_word_t e;
	} ray_row_t;

	ray_row_t dir_rows[] = '{
		// at reset, zero radius: ray through the center is tangent at distance 0 -> miss
		'{'{32'd0, 32'd0, 32'd0, 18'd65536, 18'd0, 18'd0}, 1,
		  '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0}},
		'{'{32'h7fffffff, 32'h80000000, 32'h7fffffff, 18'h1ffff, 18'h20000, 18'd0}, 0,
		  '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0}},
		'{'{32'h80000000, 32'h7fffffff, 32'h80000000, 18'h3ffff, 18'h10000, 18'h30000}, 0,
		  '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0}}
	};

	ray_row_t unit_rows[] = '{
		// from -5 on x toward +x: hit at distance 4, point (-1,0,0)
		'{'{-32'sd327680, 32'd0, 32'd0, 18'd65536, 18'd0, 18'd0}, 1,
		  '{1'b1, 31'd262144, -32'sd65536, 32'd0, 32'd0}},
		// pointing away: both roots negative -> miss
		'{'{-32'sd327680, 32'd0, 32'd0, -18'sd65536, 18'd0, 18'd0}, 1,
		  '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0}},
		// inside the sphere: far root at 1
		'{'{32'd0, 32'd0, 32'd0, 18'd0, 18'd65536, 18'd0}, 1,
		  '{1'b1, 31'd65536, 32'd0, 32'd65536, 32'd0}},
		// tangent along y at x=1
		'{'{32'd65536, -32'sd196608, 32'd0, 18'd0, 18'd65536, 18'd0}, 0,
		  '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0}},
		// clear miss
		'{'{32'd655360, 32'd0, 32'd0, 18'd0, 18'd0, 18'd65536}, 1,
		  '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0}},
		// zero direction, non-unit directions
		'{'{32'd0, 32'd0, 32'd0, 18'd0, 18'd0, 18'd0}, 0,
		  '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0}},
		'{'{-32'sd327680, 32'd0, 32'd0, 18'h1ffff, 18'h1ffff, 18'h1ffff}, 0,
		  '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0}},
		'{'{32'h80000000, 32'h80000000, 32'h80000000, 18'h20000, 18'h20000, 18'h20000}, 0,
		  '{1'b0, 31'd0, 32'd0, 32'd0, 32'd0}}
	};

	task automatic run_rows(input ray_row_t rows[]);
		foreach (rows[i]) begin
			send_ray(rows[i].r, 0);
			if (rows[i].known)
				pending_hits[$] = rows[i].e;
		end
		drain_pipe();
	endtask

	initial begin
		ray_word_t r;
		int span;
		mismatches = 0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rsi_pkg::REG_CENTER_X;
		cfg_wdata = '0;
		origin_x = '0; origin_y = '0; origin_z = '0;
		dir_x = '0; dir_y = '0; dir_z = '0;
		sph_cx = '0; sph_cy = '0; sph_cz = '0; sph_r = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_rows(dir_rows);
		set_sphere(32'd0, 32'd0, 32'd0, 32'd65536);
		run_rows(unit_rows);

		// huge radius and extreme center: saturated distance and points
		set_sphere(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		for (int i = 0; i < 8; i++) begin
			r = '{rand_crd(1 << 30), rand_crd(1 << 30), rand_crd(1 << 30),
				rand_dir(), rand_dir(), rand_dir()};
			send_ray(r, 0);
		end
		drain_pipe();

		// random phases, each with its own sphere
		for (int ph = 0; ph < 10; ph++) begin
			span = (ph % 3 == 0) ? (1 << 30) : (1 << 22);
			set_sphere(rand_crd(span), rand_crd(span), rand_crd(span),
				(ph == 9) ? 32'd0 : ((ph % 4 == 1) ? $urandom :
				$urandom_range(span / 2)));
			for (int i = 0; i < N_RANDOM / 10; i++) begin
				r.ox = $signed(sph_cx) + $signed(rand_crd(span));
				r.oy = $signed(sph_cy) + $signed(rand_crd(span));
				r.oz = $signed(sph_cz) + $signed(rand_crd(span));
				r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
				// point the x direction toward the center most of the time
				if ($urandom_range(3) != 0) begin
					r.dx = ($signed(sph_cx) > $signed(r.ox)) ? 18'($urandom_range(65536))
						: 18'(-$signed({1'b0, 17'($urandom_range(65535))}));
				end
				send_ray(r, ph % 4 != 2);
			end
			drain_pipe();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
